// ----- rtl/core/jtmp_pkg.sv -----
// Shared types, constants and helpers of the joint swing motion generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jtmp_pkg;

   localparam int ANGLE_W     = 32;
   localparam int SPEED_W     = 31;
   localparam int STEP_W      = 16;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;

   localparam int DIVIDEND_W  = 36;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = 6;
   localparam int REM_W       = 4;
   localparam int MUL_CNT_W   = 4;

   typedef logic signed [ANGLE_W-1:0] word_type;
   typedef logic [SPEED_W-1:0]        speed_type;
   typedef logic [STEP_W-1:0]         step_type;
   typedef logic [CMD_W-1:0]          cmd_type;

   localparam cmd_type CMD_TICK  = 2'd0;
   localparam cmd_type CMD_START = 2'd1;
   localparam cmd_type CMD_LOAD  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_START_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_ANGLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP   = 2'd3;

   localparam logic [REM_W-1:0] ACC_DIVISOR = 4'd12;
   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   localparam speed_type SPEED_RESET = 31'd65536;
   localparam step_type  STEP_RESET  = 16'd655;

   // Clamps a sum of two words back into the signed word range.
   function automatic word_type sat_word(input logic signed [ANGLE_W:0] x);
      word_type r;
      if (x[ANGLE_W] != x[ANGLE_W-1]) begin
         r = x[ANGLE_W] ? WORD_MIN : WORD_MAX;
      end else begin
         r = x[ANGLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jtmp_acc_div.sv -----
// Bit-serial restoring divider that forms speed_limit*25/12, saturated to a word.
// Depends on jtmp_pkg; one quotient bit is produced per cycle.
`default_nettype none

module jtmp_acc_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  jtmp_pkg::speed_type speed,
   output logic                done,
   output jtmp_pkg::word_type  acc
);
   import jtmp_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIVIDEND_W-1:0] dv_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [DIVIDEND_W-1:0] dividend;
   logic [REM_W:0]        trial;
   logic                  q_bit;
   logic [REM_W-1:0]      rem_in;

   assign dividend = ({5'd0, speed} << 4) + ({5'd0, speed} << 3) + {5'd0, speed};

   always_comb begin
      trial = {rem_ff, dv_ff[DIVIDEND_W-1]};
      q_bit = (trial >= {1'b0, ACC_DIVISOR});
      if (q_bit) begin
         rem_in = REM_W'(trial - {1'b0, ACC_DIVISOR});
      end else begin
         rem_in = trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dv_ff  <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dv_ff  <= {dv_ff[DIVIDEND_W-2:0], q_bit};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign acc  = (|dv_ff[DIVIDEND_W-1:ANGLE_W-1]) ? WORD_MAX
                                                   : {1'b0, dv_ff[ANGLE_W-2:0]};

endmodule

`default_nettype wire

// ----- rtl/core/jtmp_serial_mul.sv -----
// Bit-serial signed-by-unsigned multiplier giving floor(x*dt/2^16).
// Depends on jtmp_pkg; one bit of the time step is consumed per cycle.
`default_nettype none

module jtmp_serial_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  jtmp_pkg::word_type multiplicand,
   input  jtmp_pkg::step_type step,
   output logic               done,
   output jtmp_pkg::word_type product
);
   import jtmp_pkg::*;

   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(STEP_W - 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [MUL_CNT_W-1:0]    cnt_ff;
   word_type                x_ff;
   word_type                hi_ff;
   step_type                lo_ff;
   logic signed [ANGLE_W:0] partial;

   assign partial = {hi_ff[ANGLE_W-1], hi_ff}
                  + (lo_ff[0] ? {x_ff[ANGLE_W-1], x_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == MUL_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff  <= multiplicand;
         hi_ff <= '0;
         lo_ff <= step;
      end else if (busy_ff) begin
         hi_ff <= partial[ANGLE_W:1];
         lo_ff <= {partial[0], lo_ff[STEP_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = hi_ff;

endmodule

`default_nettype wire

// ----- rtl/core/joint_triangular_motion_profile.sv -----
// Joint swing motion generator: angle, velocity, acceleration and phase flag.
// A tick word passes through the serial acceleration divider, two passes of the serial multiplier
// (velocity, then angle) and the output state; no new word is taken until its result is loaded
// into the output register. A tick that finds the joint braked to rest skips the multiplier.
// Start and load words go straight to the output state.
// A stalled result holds the next word in its output state. Reset is synchronous, active high.
`default_nettype none

module joint_triangular_motion_profile (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  jtmp_pkg::cmd_type                    req_cmd,
   input  logic                                 req_forward,
   input  jtmp_pkg::word_type                   req_load_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output jtmp_pkg::word_type                   rsp_angle,
   output jtmp_pkg::word_type                   rsp_velocity,
   output logic                                 rsp_accel_phase_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jtmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jtmp_pkg::ANGLE_W-1:0]         csr_data
);
   import jtmp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MULV = 3'd2;
   localparam logic [2:0] S_MULA = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   word_type   start_ff, end_ff;
   speed_type  speed_ff;
   step_type   step_ff;

   word_type   angle_ff, angle_in;
   word_type   vel_ff, vel_in;
   word_type   accel_ff, accel_in;
   logic       phase_ff, phase_in;
   logic       fwd_ff, fwd_in;

   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_angle_ff, rsp_velocity_ff;
   logic       rsp_phase_ff;
   logic       out_load;

   logic       accept;
   logic       div_start, div_done;
   word_type   acc;
   logic       mul_start, mul_done;
   word_type   mul_x, mul_p;

   logic                    toward;
   word_type                accel_sel;
   logic                    vel_pos, vel_neg, advance;
   logic [ANGLE_W:0]        vel_mag;
   word_type                vel_sel;
   word_type                angle_sum;
   logic signed [ANGLE_W:0] twice_angle, twice_mid;

   jtmp_acc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .speed (speed_ff),
      .done  (div_done),
      .acc   (acc)
   );

   jtmp_serial_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_x),
      .step         (step_ff),
      .done         (mul_done),
      .product      (mul_p)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign div_start = accept && (req_cmd == CMD_TICK);

   always_comb begin
      toward    = fwd_ff ? (angle_ff != end_ff) : (angle_ff != start_ff);
      if (toward) begin
         accel_sel = (phase_ff ^ fwd_ff) ? acc : -acc;
      end else begin
         accel_sel = accel_ff;
      end
      vel_pos = !vel_ff[ANGLE_W-1] && (vel_ff != '0);
      vel_neg = vel_ff[ANGLE_W-1];
      vel_mag = vel_neg ? ((ANGLE_W+1)'(0) - {vel_ff[ANGLE_W-1], vel_ff})
                        : {1'b0, vel_ff};
      if (phase_ff) begin
         advance = fwd_ff ? vel_pos : vel_neg;
      end else begin
         advance = (vel_mag <= {2'b00, speed_ff});
      end
      if (advance) begin
         vel_sel = sat_word({vel_ff[ANGLE_W-1], vel_ff} + {mul_p[ANGLE_W-1], mul_p});
      end else if (phase_ff) begin
         vel_sel = '0;
      end else begin
         vel_sel = vel_ff;
      end
      angle_sum   = sat_word({angle_ff[ANGLE_W-1], angle_ff} + {mul_p[ANGLE_W-1], mul_p});
      twice_angle = {angle_sum, 1'b0};
      twice_mid   = {start_ff[ANGLE_W-1], start_ff} + {end_ff[ANGLE_W-1], end_ff};
   end

   always_comb begin
      state_in  = state_ff;
      angle_in  = angle_ff;
      vel_in    = vel_ff;
      accel_in  = accel_ff;
      phase_in  = phase_ff;
      fwd_in    = fwd_ff;
      mul_start = 1'b0;
      mul_x     = accel_sel;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fwd_in = req_forward;
               case (req_cmd)
                  CMD_TICK: begin
                     state_in = S_DIV;
                  end
                  CMD_START: begin
                     phase_in = 1'b0;
                     state_in = S_OUT;
                  end
                  CMD_LOAD: begin
                     angle_in = req_load_value;
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (phase_ff && (vel_ff == '0)) begin
                  accel_in = '0;
                  state_in = S_OUT;
               end else begin
                  accel_in  = accel_sel;
                  mul_x     = accel_sel;
                  mul_start = 1'b1;
                  state_in  = S_MULV;
               end
            end
         end
         S_MULV: begin
            if (mul_done) begin
               vel_in    = vel_sel;
               mul_x     = vel_sel;
               mul_start = 1'b1;
               state_in  = S_MULA;
            end
         end
         S_MULA: begin
            if (mul_done) begin
               angle_in = angle_sum;
               if (!phase_ff && ((vel_pos && (twice_angle >= twice_mid)) ||
                                 (vel_neg && (twice_angle <= twice_mid)))) begin
                  phase_in = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         angle_ff     <= '0;
         vel_ff       <= '0;
         accel_ff     <= '0;
         phase_ff     <= 1'b1;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         speed_ff     <= SPEED_RESET;
         step_ff      <= STEP_RESET;
      end else begin
         state_ff     <= state_in;
         angle_ff     <= angle_in;
         vel_ff       <= vel_in;
         accel_ff     <= accel_in;
         phase_ff     <= phase_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_ANGLE: start_ff <= csr_data;
               REG_END_ANGLE:   end_ff   <= csr_data;
               REG_SPEED_LIMIT: speed_ff <= csr_data[SPEED_W-1:0];
               REG_TIME_STEP:   step_ff  <= csr_data[STEP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_angle_ff    <= angle_ff;
         rsp_velocity_ff <= vel_ff;
         rsp_phase_ff    <= phase_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_angle            = rsp_angle_ff;
   assign rsp_velocity         = rsp_velocity_ff;
   assign rsp_accel_phase_done = rsp_phase_ff;

endmodule

`default_nettype wire

// ----- rtl/core/jtmp_checker.sv -----
// Port-level checks of the joint swing motion generator, bound to its top level.
// Depends on jtmp_pkg for the command codes.
`default_nettype none

module jtmp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input jtmp_pkg::cmd_type          req_cmd,
   input jtmp_pkg::word_type         req_load_value,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input jtmp_pkg::word_type         rsp_angle,
   input jtmp_pkg::word_type         rsp_velocity,
   input logic                       rsp_accel_phase_done
);
   import jtmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_angle) && $stable(rsp_velocity))
      else $error("stalled result word changed");

   a_start_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_START) && !rsp_valid
      |=> ##1 (rsp_valid && !rsp_accel_phase_done))
      else $error("start word did not clear the phase flag in its result");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_LOAD) && !rsp_valid
      |=> ##1 (rsp_valid && (rsp_angle == $past(req_load_value, 2))))
      else $error("load word result does not show the loaded angle");

endmodule

bind joint_triangular_motion_profile jtmp_checker u_jtmp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_cmd              (req_cmd),
   .req_load_value       (req_load_value),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_angle            (rsp_angle),
   .rsp_velocity         (rsp_velocity),
   .rsp_accel_phase_done (rsp_accel_phase_done)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the joint swing motion generator: a scoreboard class predicts
// every result word, while plain tasks drive the request, result and register channels.
// Depends on jtmp_pkg and joint_triangular_motion_profile only.
`default_nettype none

module tb_top;
   import jtmp_pkg::*;

   localparam int      CYCLE_LIMIT     = 1000000;
   localparam int      PHASES          = 12;
   localparam int      WORDS_PER_PHASE = 110;
   localparam int      HOLD_CYCLES     = 400;
   localparam int      SETTLE_CYCLES   = 100;
   localparam cmd_type CMD_SPARE       = 2'd3;
   localparam longint  ANGLE_HI        = WORD_MAX;
   localparam longint  ANGLE_LO        = WORD_MIN;

   typedef struct {
      word_type angle;
      word_type velocity;
      logic     phase_done;
   } motion_result_type;

   class motion_scoreboard;
      longint start_ang, end_ang, top_speed, dt;
      longint angle, vel, accel;
      bit mid_passed;
      int errors;
      motion_result_type expected_states[$];

      function new();
         start_ang  = 0;
         end_ang    = 0;
         top_speed  = SPEED_RESET;
         dt         = STEP_RESET;
         angle      = 0;
         vel        = 0;
         accel      = 0;
         mid_passed = 1'b1;
         errors     = 0;
      endfunction

      static function longint clamp_word(input longint x);
         if (x > ANGLE_HI) begin
            return ANGLE_HI;
         end
         if (x < ANGLE_LO) begin
            return ANGLE_LO;
         end
         return x;
      endfunction

      // The arithmetic shift floors, which is what the block's tick products need.
      function longint scale_by_dt(input longint x);
         return (x * dt) >>> 16;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
         case (idx)
            REG_START_ANGLE: start_ang = word_type'(data);
            REG_END_ANGLE:   end_ang   = word_type'(data);
            REG_SPEED_LIMIT: top_speed = longint'(data[SPEED_W-1:0]);
            REG_TIME_STEP:   dt        = longint'(data[STEP_W-1:0]);
            default: ;
         endcase
      endfunction

      function void motion_tick(input bit fwd);
         longint acc, mag, twice_mid;
         acc = clamp_word((top_speed * 25) / 12);
         if (mid_passed) begin
            if (vel == 0) begin
               accel = 0;
               return;
            end
            if (fwd) begin
               if (angle != end_ang) accel = -acc;
               if (vel > 0) vel = clamp_word(vel + scale_by_dt(accel));
               else vel = 0;
            end else begin
               if (angle != start_ang) accel = acc;
               if (vel < 0) vel = clamp_word(vel + scale_by_dt(accel));
               else vel = 0;
            end
            angle = clamp_word(angle + scale_by_dt(vel));
         end else begin
            twice_mid = start_ang + end_ang;
            if (fwd) begin
               if (angle != end_ang) accel = acc;
            end else begin
               if (angle != start_ang) accel = -acc;
            end
            mag = (vel < 0) ? -vel : vel;
            if (mag <= top_speed) vel = clamp_word(vel + scale_by_dt(accel));
            angle = clamp_word(angle + scale_by_dt(vel));
            if (vel > 0 && 2 * angle >= twice_mid) mid_passed = 1'b1;
            if (vel < 0 && 2 * angle <= twice_mid) mid_passed = 1'b1;
         end
      endfunction

      function void note_request(input cmd_type c, input logic fwd, input word_type value);
         motion_result_type r;
         case (c)
            CMD_TICK:  motion_tick(fwd);
            CMD_START: mid_passed = 1'b0;
            CMD_LOAD:  angle = value;
            default: ;
         endcase
         r.angle      = angle[ANGLE_W-1:0];
         r.velocity   = vel[ANGLE_W-1:0];
         r.phase_done = mid_passed;
         expected_states.push_back(r);
      endfunction

      function int pending();
         return expected_states.size();
      endfunction

      task report(input string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(input word_type a, input word_type v, input logic done);
         motion_result_type want;
         if (expected_states.size() == 0) begin
            report($sformatf("result word with nothing pending, angle %0d", a));
            return;
         end
         want = expected_states.pop_front();
         if (a !== want.angle)
            report($sformatf("angle %0d, expected %0d", a, want.angle));
         if (v !== want.velocity)
            report($sformatf("velocity %0d, expected %0d", v, want.velocity));
         if (done !== want.phase_done)
            report($sformatf("phase flag %b, expected %b", done, want.phase_done));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   cmd_type              req_cmd;
   logic                 req_forward;
   word_type             req_load_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   word_type             rsp_angle;
   word_type             rsp_velocity;
   logic                 rsp_accel_phase_done;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ANGLE_W-1:0]   csr_data;

   motion_scoreboard board;
   bit               quiet;
   int               long_hold;
   int               words_sent;
   int               cycle_count = 0;
   longint           cfg_start, cfg_end;

   joint_triangular_motion_profile dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_forward          (req_forward),
      .req_load_value       (req_load_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_angle            (rsp_angle),
      .rsp_velocity         (rsp_velocity),
      .rsp_accel_phase_done (rsp_accel_phase_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input cmd_type c, input logic fwd, input word_type value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= c;
      req_forward    <= fwd;
      req_load_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(c, fwd, value);
      words_sent++;
   endtask

   task automatic take_results();
      int hold;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 18);
         if (long_hold > 0) begin
            hold      = long_hold;
            long_hold = 0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_result(rsp_angle, rsp_velocity, rsp_accel_phase_done);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int ph);
      longint           spd, step_len, span, base, far;
      logic [STEP_W-1:0] step;
      case (ph)
         0: begin
            cfg_start = ANGLE_LO;
            cfg_end   = ANGLE_HI;
            spd       = 64'h7FFF_FFFF;
            step      = '1;
         end
         1: begin
            cfg_start = ANGLE_HI;
            cfg_end   = ANGLE_LO;
            spd       = 0;
            step      = '0;
         end
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               cfg_start = word_type'($urandom);
               cfg_end   = word_type'($urandom);
               spd       = longint'($urandom & 32'h7FFF_FFFF);
               step      = 16'($urandom);
            end else begin
               spd      = longint'($urandom_range(1, 1 << 22));
               step     = 16'($urandom_range(64, 65535));
               step_len = ((spd * longint'(step)) >> 16) + 1;
               span     = step_len * $urandom_range(2, 40);
               base     = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
               far      = $urandom_range(0, 1) ? base + span : base - span;
               cfg_start = base;
               cfg_end   = motion_scoreboard::clamp_word(far);
            end
         end
      endcase
      write_reg(REG_START_ANGLE, cfg_start[ANGLE_W-1:0]);
      write_reg(REG_END_ANGLE, cfg_end[ANGLE_W-1:0]);
      write_reg(REG_SPEED_LIMIT, spd[ANGLE_W-1:0]);
      write_reg(REG_TIME_STEP, {16'b0, step});
   endtask

   // A swing is an optional load near its origin, a start word and a run of ticks in one
   // direction; now and then the direction flips or the words are plain noise.
   task automatic run_motion();
      logic   dir;
      int     ticks;
      longint origin;
      dir   = 1'($urandom_range(0, 1));
      ticks = $urandom_range(4, 50);
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 8))
            send_word(cmd_type'($urandom_range(0, 3)), 1'($urandom), word_type'($urandom));
      end else begin
         origin = dir ? cfg_start : cfg_end;
         origin = motion_scoreboard::clamp_word(origin + $urandom_range(0, 16) - 8);
         if ($urandom_range(0, 3) != 0)
            send_word(CMD_LOAD, 1'($urandom), word_type'(origin));
         send_word(CMD_START, 1'($urandom), word_type'($urandom));
         repeat (ticks)
            send_word(CMD_TICK, ($urandom_range(0, 19) == 0) ? !dir : dir, word_type'($urandom));
      end
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_TICK;
      req_forward    = 1'b0;
      req_load_value = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = REG_START_ANGLE;
      csr_data       = '0;
      quiet          = 1'b0;
      long_hold      = 0;
      words_sent     = 0;
      cfg_start      = 0;
      cfg_end        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // A still joint after reset, and the spare command code.
      send_word(CMD_TICK, 1'b1, '0);
      send_word(CMD_SPARE, 1'b1, word_type'(32'hFFFF_FFFF));
      drain_results();

      // One-second ticks: the speed cap, the midpoint, a braking overshoot and the hold.
      cfg_start = -262144;
      cfg_end   = 262144;
      write_reg(REG_START_ANGLE, cfg_start[ANGLE_W-1:0]);
      write_reg(REG_END_ANGLE, cfg_end[ANGLE_W-1:0]);
      write_reg(REG_SPEED_LIMIT, 32'd65536);
      write_reg(REG_TIME_STEP, 32'd65535);
      send_word(CMD_LOAD, 1'b0, word_type'(cfg_start));
      send_word(CMD_START, 1'b1, '0);
      repeat (5) send_word(CMD_TICK, 1'b1, word_type'($urandom));
      send_word(CMD_START, 1'b0, '0);
      repeat (6) send_word(CMD_TICK, 1'b0, word_type'($urandom));
      send_word(CMD_LOAD, 1'b1, WORD_MAX);
      send_word(CMD_TICK, 1'b1, '0);
      send_word(CMD_LOAD, 1'b0, WORD_MIN);
      send_word(CMD_TICK, 1'b0, '1);
      send_word(CMD_START, 1'b0, '1);
      send_word(CMD_TICK, 1'b0, '0);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         configure(ph);
         words_sent = 0;
         if (ph == 2) begin
            quiet     = 1'b1;
            long_hold = HOLD_CYCLES;
            repeat (16) send_word(CMD_TICK, 1'($urandom), word_type'($urandom));
         end
         while (words_sent < WORDS_PER_PHASE) run_motion();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d result words never arrived", board.pending()));
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/jtmp_pkg.sv
rtl/core/jtmp_acc_div.sv
rtl/core/jtmp_serial_mul.sv
rtl/core/joint_triangular_motion_profile.sv
rtl/core/jtmp_checker.sv
bench/tb_top.sv
